[rtl/sorted_timer_queue_core_macros.svh]
// ---------------------------------------------------------------------------
// sorted timer queue assertion macros
// concurrent checks on clk, quiet while rst_n is low, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMER_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every edge out of reset
`define STQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sorted timer queue check failed");

// consequent holds under non-overlapping implication from the antecedent
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted timer queue check failed");

`else

`define STQ_ASSERT_ALWAYS(lbl, expr)
`define STQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/stq_pkg.sv]
// ---------------------------------------------------------------------------
// stq_pkg
// field widths, command and result codes, sequencer states
// ---------------------------------------------------------------------------
package stq_pkg;

    localparam int ID_W   = 4;
    localparam int TIME_W = 64;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_UNSET = 2'd1,
        CMD_RESET = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FIRED       = 2'd0,
        KIND_SET_OK      = 2'd1,
        KIND_SET_REFUSED = 2'd2,
        KIND_DONE        = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL_CHK,
        ST_INS_RD,
        ST_INS_WK,
        ST_INS_CHK,
        ST_REF_ORD,
        ST_REF_WK,
        ST_REF_SET,
        ST_T_RD,
        ST_T_WK,
        ST_T_CHK,
        ST_T_FRD,
        ST_T_FOUT,
        ST_T_FWAIT,
        ST_T_SH_RD,
        ST_T_SH_WR,
        ST_LOAD,
        ST_WAIT
    } state_t;

endpackage

[rtl/sorted_timer_queue_core.sv]
// ---------------------------------------------------------------------------
// sorted_timer_queue_core
// timer list sorted by wake time, kept in an order ram and a wake-time ram
// ---------------------------------------------------------------------------
// Usage: one command item enters on in_valid/in_ready (command, waiter_id,
// wake_time, now_time). Results leave on out_valid/out_ready, one item per
// handshake; last marks the final item of a command. A tick gives one fired
// item per due waiter in queue order, then a status item. alarm_armed and
// alarm_time give the state after the whole command in every item.
// One command is worked at a time; in_ready is high only when idle, and the
// next command is taken the cycle after the final result item is accepted.
// Work per command: set is a tail-first insert, with a read, a wake-time
// lookup and a check step per moved entry; unset searches and compacts in
// one pass; reset is unset plus set. A tick scans waiters with a read, a
// lookup and a check step each, then gives each fired item with output wait,
// moves the remaining entries to the head, then gives the status. The order
// ram read is registered and the wake lookup is chained after it.
// Reset clears pending flags, count and alarm; the rams need no clearing.
// A stalled receiver holds the sequencer in its output wait state.
// ---------------------------------------------------------------------------
`include "sorted_timer_queue_core_macros.svh"

module sorted_timer_queue_core
    import stq_pkg::*;
#(
    parameter int WAITERS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [ID_W-1:0]   waiter_id,
    input  logic [TIME_W-1:0] wake_time,
    input  logic [TIME_W-1:0] now_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [ID_W-1:0]   waiter_id_res,
    output logic              was_pending,
    output logic              alarm_armed,
    output logic [TIME_W-1:0] alarm_time,
    output logic              last
);

    localparam int AW = $clog2(WAITERS);
    localparam int CW = $clog2(WAITERS + 1);

    state_t state_reg, state_next;

    cmd_t              cmd_reg;
    kind_t             kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] wt_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     count_reg;
    logic [TIME_W-1:0] earliest_reg;
    logic              found_reg;
    logic              was_reg;
    logic [AW-1:0]     slot_reg;
    logic [WAITERS-1:0] pending_reg;

    logic              out_valid_reg;
    kind_t             res_kind_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic              res_was_reg;
    logic              res_armed_reg;
    logic [TIME_W-1:0] res_time_reg;
    logic              res_last_reg;

    // ram ports
    logic              ord_we;
    logic [AW-1:0]     ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic              wk_we;
    logic [AW-1:0]     wk_waddr, wk_raddr;
    logic [TIME_W-1:0] wk_rdata;

    logic              in_acc, out_acc;
    logic              id_ok, in_pend;
    logic [AW-1:0]     in_idx, id_idx;
    logic              wake_later, wake_due;
    logic              del_more;

    stq_ram #(.WIDTH(AW), .DEPTH(WAITERS)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    stq_ram #(.WIDTH(TIME_W), .DEPTH(WAITERS)) u_wake_ram (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wake_time),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    // handshake and decode helpers
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_acc    = out_valid_reg && out_ready;
    assign id_ok      = 32'(waiter_id) < WAITERS;
    assign in_idx     = AW'(waiter_id);
    assign id_idx     = AW'(id_reg);
    assign in_pend    = id_ok && pending_reg[in_idx];
    assign wake_later = wk_rdata > wt_reg;
    assign wake_due   = wk_rdata <= now_reg;
    assign del_more   = CW'(k_reg + 1'b1) < count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd_t'(command) == CMD_TICK)
                        state_next = ST_T_RD;
                    else if (!id_ok)
                        state_next = ST_LOAD;
                    else if (cmd_t'(command) == CMD_SET)
                        state_next = in_pend ? ST_LOAD : ST_INS_RD;
                    else if (cmd_t'(command) == CMD_UNSET)
                        state_next = in_pend ? ST_DEL_RD : ST_LOAD;
                    else
                        state_next = in_pend ? ST_DEL_RD : ST_INS_RD;
                end
            end
            ST_DEL_RD:  state_next = ST_DEL_CHK;
            ST_DEL_CHK:
            begin
                if (del_more)
                    state_next = ST_DEL_RD;
                else if (cmd_reg == CMD_RESET)
                    state_next = ST_INS_RD;
                else
                    state_next = ST_REF_ORD;
            end
            ST_INS_RD:  state_next = (k_reg == '0) ? ST_REF_ORD : ST_INS_WK;
            ST_INS_WK:  state_next = ST_INS_CHK;
            ST_INS_CHK: state_next = wake_later ? ST_INS_RD : ST_REF_ORD;
            ST_REF_ORD: state_next = (count_reg == '0) ? ST_LOAD : ST_REF_WK;
            ST_REF_WK:  state_next = ST_REF_SET;
            ST_REF_SET: state_next = ST_LOAD;
            ST_T_RD:    state_next = (n_reg == count_reg) ? ST_T_FRD : ST_T_WK;
            ST_T_WK:    state_next = ST_T_CHK;
            ST_T_CHK:   state_next = wake_due ? ST_T_RD : ST_T_FRD;
            ST_T_FRD:   state_next = (k_reg == n_reg) ? ST_T_SH_RD : ST_T_FOUT;
            ST_T_FOUT:  state_next = ST_T_FWAIT;
            ST_T_FWAIT: state_next = out_acc ? ST_T_FRD : ST_T_FWAIT;
            ST_T_SH_RD: state_next = (k_reg == count_reg) ? ST_LOAD : ST_T_SH_WR;
            ST_T_SH_WR: state_next = ST_T_SH_RD;
            ST_LOAD:    state_next = ST_WAIT;
            ST_WAIT:    state_next = out_acc ? ST_IDLE : ST_WAIT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ram control
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        ord_raddr = '0;
        wk_we     = 1'b0;
        wk_waddr  = in_idx;
        wk_raddr  = ord_rdata;
        case (state_reg)
            ST_IDLE:
            begin
                wk_we = in_acc && id_ok && (cmd_t'(command) == CMD_RESET
                        || (cmd_t'(command) == CMD_SET && !in_pend));
            end
            ST_DEL_RD:  ord_raddr = AW'(k_reg);
            ST_DEL_CHK:
            begin
                ord_we    = found_reg;
                ord_waddr = AW'(k_reg - 1'b1);
                ord_wdata = ord_rdata;
            end
            ST_INS_RD:
            begin
                ord_raddr = AW'(k_reg - 1'b1);
                ord_we    = (k_reg == '0);
                ord_waddr = '0;
                ord_wdata = id_idx;
            end
            ST_INS_CHK:
            begin
                ord_we    = 1'b1;
                ord_waddr = AW'(k_reg);
                ord_wdata = wake_later ? slot_reg : id_idx;
            end
            ST_T_RD:    ord_raddr = AW'(n_reg);
            ST_T_FRD:   ord_raddr = AW'(k_reg);
            ST_T_SH_RD: ord_raddr = AW'(k_reg + n_reg);
            ST_T_SH_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = AW'(k_reg);
                ord_wdata = ord_rdata;
            end
            default:
            begin
                ord_we = 1'b0;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            earliest_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_DEL_CHK:
                begin
                    if (!del_more)
                    begin
                        count_reg           <= CW'(count_reg - 1'b1);
                        pending_reg[id_idx] <= 1'b0;
                    end
                end
                ST_INS_RD:
                begin
                    if (k_reg == '0)
                    begin
                        count_reg           <= CW'(count_reg + 1'b1);
                        pending_reg[id_idx] <= 1'b1;
                    end
                end
                ST_INS_CHK:
                begin
                    if (!wake_later)
                    begin
                        count_reg           <= CW'(count_reg + 1'b1);
                        pending_reg[id_idx] <= 1'b1;
                    end
                end
                ST_REF_ORD:
                begin
                    if (count_reg == '0)
                        earliest_reg <= '0;
                end
                ST_REF_SET: earliest_reg <= wk_rdata;
                ST_T_RD:
                begin
                    if (n_reg == count_reg)
                    begin
                        count_reg    <= '0;
                        earliest_reg <= '0;
                    end
                end
                ST_T_CHK:
                begin
                    if (!wake_due)
                    begin
                        count_reg    <= CW'(count_reg - n_reg);
                        earliest_reg <= wk_rdata;
                    end
                end
                ST_T_FOUT: pending_reg[ord_rdata] <= 1'b0;
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // command payload and loop indexes
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_reg   <= cmd_t'(command);
                    id_reg    <= waiter_id;
                    wt_reg    <= wake_time;
                    now_reg   <= now_time;
                    was_reg   <= 1'b0;
                    found_reg <= 1'b0;
                    n_reg     <= '0;
                    if (cmd_t'(command) == CMD_SET && !in_pend && id_ok)
                        k_reg <= count_reg;
                    else if (cmd_t'(command) == CMD_RESET && !in_pend)
                        k_reg <= count_reg;
                    else
                        k_reg <= '0;
                    if (cmd_t'(command) == CMD_SET && id_ok)
                        kind_reg <= in_pend ? KIND_SET_REFUSED : KIND_SET_OK;
                    else
                        kind_reg <= KIND_DONE;
                end
            end
            ST_DEL_CHK:
            begin
                if (!found_reg && ord_rdata == id_idx)
                    found_reg <= 1'b1;
                if (del_more)
                begin
                    k_reg <= CW'(k_reg + 1'b1);
                end
                else
                begin
                    was_reg <= 1'b1;
                    k_reg   <= CW'(count_reg - 1'b1);
                end
            end
            ST_INS_WK:  slot_reg <= ord_rdata;
            ST_INS_CHK:
            begin
                if (wake_later)
                    k_reg <= CW'(k_reg - 1'b1);
            end
            ST_T_CHK:
            begin
                if (wake_due)
                    n_reg <= CW'(n_reg + 1'b1);
                k_reg <= '0;
            end
            ST_T_RD:    k_reg <= '0;
            ST_T_FRD:
            begin
                if (k_reg == n_reg)
                    k_reg <= '0;
            end
            ST_T_FWAIT:
            begin
                if (out_acc)
                    k_reg <= CW'(k_reg + 1'b1);
            end
            ST_T_SH_WR: k_reg <= CW'(k_reg + 1'b1);
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_LOAD || state_reg == ST_T_FOUT)
            out_valid_reg <= 1'b1;
        else if (out_acc)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD || state_reg == ST_T_FOUT)
        begin
            res_armed_reg <= (count_reg != '0);
            res_time_reg  <= (count_reg != '0) ? earliest_reg : '0;
            if (state_reg == ST_T_FOUT)
            begin
                res_kind_reg <= KIND_FIRED;
                res_id_reg   <= ID_W'(ord_rdata);
                res_was_reg  <= 1'b0;
                res_last_reg <= 1'b0;
            end
            else
            begin
                res_kind_reg <= kind_reg;
                res_id_reg   <= (cmd_reg == CMD_TICK) ? '0 : id_reg;
                res_was_reg  <= was_reg;
                res_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = res_kind_reg;
    assign waiter_id_res = res_id_reg;
    assign was_pending   = res_was_reg;
    assign alarm_armed   = res_armed_reg;
    assign alarm_time    = res_time_reg;
    assign last          = res_last_reg;

    // checks
    `STQ_ASSERT_ALWAYS(a_idle_no_result, !(state_reg == ST_IDLE && out_valid_reg))
    `STQ_ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= WAITERS)
    `STQ_ASSERT_ALWAYS(a_count_matches_flags,
        !(state_reg == ST_IDLE) || ($countones(pending_reg) == 32'(count_reg)))
    `STQ_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_reg != ST_IDLE)
    `STQ_ASSERT_ALWAYS(a_armed_when_nonempty,
        !(state_reg == ST_WAIT) || (res_armed_reg == (count_reg != '0)))

endmodule

[rtl/stq_ram.sv]
// ---------------------------------------------------------------------------
// stq_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
